// ===== sv/tcw_pkg.sv =====
// shared types, codes and constants for the text console cell writer
package tcw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int POS_W  = 11;
    localparam int CELL_W = 16;
    localparam int WIDE_W = 16;

    localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ   = 2'd2;
    localparam logic [KIND_W-1:0] KIND_SETCUR = 2'd3;

    localparam logic [BYTE_W-1:0] BLANK_CHAR      = 8'h20;
    localparam logic [BYTE_W-1:0] NEWLINE_CHAR    = 8'h0a;
    localparam logic [BYTE_W-1:0] BLANK_COLOR_RST = 8'h0f;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [BYTE_W-1:0] character;
        logic [BYTE_W-1:0] color;
        logic [POS_W-1:0]  position;
    } tcw_in_t;

    typedef struct packed {
        logic [CELL_W-1:0] cell_value;
        logic [POS_W-1:0]  cursor_position;
        logic              scrolled;
    } tcw_out_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_PUT,
        S_SCR_RD,
        S_SCR_WR,
        S_FILL,
        S_RD_ISSUE,
        S_RD_WAIT,
        S_SETCUR,
        S_DONE
    } tcw_state_t;

endpackage

// ===== sv/tcw_ram.sv =====
// screen cell store, one write port and one registered read port
module tcw_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = COLUMNS_DEF * ROWS_DEF,
    parameter int ADDR_W = $clog2(COLUMNS_DEF * ROWS_DEF)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [CELL_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [CELL_W-1:0] rdata
);

    logic [CELL_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

// ===== sv/text_console_cell_writer_core.sv =====
// text console cell store with cursor, scroll and clear sequencer
//
//  channel | direction | handshake               | word
//  in      | input     | in_valid / in_ready     | tcw_in_t
//  out     | output    | out_valid / out_ready   | tcw_out_t
//  cfg     | input     | cfg_we (no wait)        | blank color byte
//
// put: accept, cell write (none for newline), load; read cell: accept, read
// issue, read wait (skipped off screen), load; set cursor: accept, row
// subtractions down to the target row, load; clear: each cell blanked in turn
// through the single memory write port; a scroll copies each cell up a row,
// then blanks the bottom row; after reset a clearing pass runs before in_ready
// rises; a stalled output holds the result in the done state until taken
module text_console_cell_writer_core
    import tcw_pkg::*;
#(
    parameter int COLUMNS = COLUMNS_DEF,
    parameter int ROWS    = ROWS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  tcw_in_t           in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output tcw_out_t          out_data,
    input  logic              cfg_we,
    input  logic [BYTE_W-1:0] cfg_data
);

    localparam int CELL_COUNT = COLUMNS * ROWS;
    localparam int ADDR_W     = $clog2(CELL_COUNT);
    localparam int COL_W      = $clog2(COLUMNS);

    tcw_state_t        state_reg, state_next;
    tcw_in_t           item_reg, item_next;
    logic [ADDR_W-1:0] cursor_reg, cursor_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ADDR_W-1:0] rem_reg, rem_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CELL_W-1:0] fill_data_reg, fill_data_next;
    logic [CELL_W-1:0] res_value_reg, res_value_next;
    logic              res_scrolled_reg, res_scrolled_next;
    logic              out_valid_reg, out_valid_next;
    tcw_out_t          out_data_reg, out_data_next;
    logic [BYTE_W-1:0] blank_color_reg;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [CELL_W-1:0] mem_wdata;
    logic [ADDR_W-1:0] mem_raddr;
    logic [CELL_W-1:0] mem_rdata;

    logic [WIDE_W-1:0] pos_wide;
    logic [WIDE_W-1:0] cursor_wide;
    logic [WIDE_W-1:0] col_wide;
    logic [WIDE_W-1:0] adv_wide;
    logic              pos_ok;
    logic              is_newline;
    logic              col_last;
    logic              wrap;
    logic              rem_ge;
    logic              fill_last;
    logic              copy_last;
    logic              out_free;

    tcw_ram #(
        .DEPTH  (CELL_COUNT),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign pos_wide    = WIDE_W'(item_reg.position);
    assign cursor_wide = WIDE_W'(cursor_reg);
    assign col_wide    = WIDE_W'(col_reg);
    assign pos_ok      = pos_wide < WIDE_W'(CELL_COUNT);
    assign is_newline  = item_reg.character == NEWLINE_CHAR;
    assign col_last    = col_reg == COL_W'(COLUMNS - 1);
    assign adv_wide    = is_newline ? (cursor_wide - col_wide + WIDE_W'(COLUMNS))
                                    : (cursor_wide + WIDE_W'(1));
    assign wrap        = adv_wide >= WIDE_W'(CELL_COUNT);
    assign rem_ge      = rem_reg >= ADDR_W'(COLUMNS);
    assign fill_last   = addr_reg == ADDR_W'(CELL_COUNT - 1);
    assign copy_last   = addr_reg == ADDR_W'(CELL_COUNT - COLUMNS - 1);
    assign out_free    = !out_valid_reg || out_ready;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_INIT:
            begin
                if (fill_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    case (in_data.kind)
                        KIND_PUT:    state_next = S_PUT;
                        KIND_CLEAR:  state_next = S_FILL;
                        KIND_READ:   state_next = S_RD_ISSUE;
                        KIND_SETCUR: state_next = S_SETCUR;
                        default:     state_next = S_IDLE;
                    endcase
                end
            end
            S_PUT:      state_next = wrap ? S_SCR_RD : S_DONE;
            S_SCR_RD:   state_next = S_SCR_WR;
            S_SCR_WR:   state_next = copy_last ? S_FILL : S_SCR_RD;
            S_FILL:     state_next = fill_last ? S_DONE : S_FILL;
            S_RD_ISSUE: state_next = pos_ok ? S_RD_WAIT : S_DONE;
            S_RD_WAIT:  state_next = S_DONE;
            S_SETCUR:
            begin
                if (!pos_ok || !rem_ge)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        item_next         = item_reg;
        cursor_next       = cursor_reg;
        col_next          = col_reg;
        rem_next          = rem_reg;
        addr_next         = addr_reg;
        fill_data_next    = fill_data_reg;
        res_value_next    = res_value_reg;
        res_scrolled_next = res_scrolled_reg;
        out_data_next     = out_data_reg;
        out_valid_next    = out_valid_reg && !out_ready;
        mem_we            = 1'b0;
        mem_waddr         = addr_reg;
        mem_wdata         = fill_data_reg;
        mem_raddr         = addr_reg;
        case (state_reg)
            S_INIT:
            begin
                mem_we    = 1'b1;
                mem_wdata = {BLANK_COLOR_RST, BLANK_CHAR};
                addr_next = fill_last ? '0 : addr_reg + ADDR_W'(1);
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    item_next         = in_data;
                    addr_next         = '0;
                    fill_data_next    = {blank_color_reg, BLANK_CHAR};
                    rem_next          = ADDR_W'(in_data.position);
                    res_value_next    = '0;
                    res_scrolled_next = 1'b0;
                    if (in_data.kind == KIND_CLEAR)
                    begin
                        cursor_next = '0;
                        col_next    = '0;
                    end
                end
            end
            S_PUT:
            begin
                if (!is_newline)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = cursor_reg;
                    mem_wdata = {item_reg.color, item_reg.character};
                end
                if (wrap)
                begin
                    cursor_next       = ADDR_W'(CELL_COUNT - COLUMNS);
                    col_next          = '0;
                    res_scrolled_next = 1'b1;
                    addr_next         = '0;
                end
                else
                begin
                    cursor_next = ADDR_W'(adv_wide);
                    col_next    = (is_newline || col_last) ? '0 : col_reg + COL_W'(1);
                end
            end
            S_SCR_RD:
            begin
                mem_raddr = addr_reg + ADDR_W'(COLUMNS);
            end
            S_SCR_WR:
            begin
                mem_we    = 1'b1;
                mem_wdata = mem_rdata;
                addr_next = copy_last ? ADDR_W'(CELL_COUNT - COLUMNS) : addr_reg + ADDR_W'(1);
            end
            S_FILL:
            begin
                mem_we    = 1'b1;
                addr_next = addr_reg + ADDR_W'(1);
            end
            S_RD_ISSUE:
            begin
                mem_raddr = ADDR_W'(pos_wide);
            end
            S_RD_WAIT:
            begin
                res_value_next = mem_rdata;
            end
            S_SETCUR:
            begin
                if (pos_ok)
                begin
                    if (rem_ge)
                    begin
                        rem_next = rem_reg - ADDR_W'(COLUMNS);
                    end
                    else
                    begin
                        cursor_next = ADDR_W'(pos_wide);
                        col_next    = COL_W'(rem_reg);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next                = 1'b1;
                    out_data_next.cell_value      = res_value_reg;
                    out_data_next.cursor_position = cursor_wide[POS_W-1:0];
                    out_data_next.scrolled        = res_scrolled_reg;
                end
            end
            default:
            begin
                out_valid_next = out_valid_reg && !out_ready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_INIT;
            cursor_reg      <= '0;
            col_reg         <= '0;
            addr_reg        <= '0;
            out_valid_reg   <= 1'b0;
            blank_color_reg <= BLANK_COLOR_RST;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            col_reg       <= col_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                blank_color_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        rem_reg          <= rem_next;
        fill_data_reg    <= fill_data_next;
        res_value_reg    <= res_value_next;
        res_scrolled_reg <= res_scrolled_next;
        out_data_reg     <= out_data_next;
    end

    // one word in flight at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("new word taken while the sequencer is busy");

    // cursor stays on screen
    assert property (@(posedge clk) disable iff (!rst_n)
        WIDE_W'(cursor_reg) < WIDE_W'(CELL_COUNT))
    else $error("cursor left the screen");

    // cell writes stay inside the store
    assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> WIDE_W'(mem_waddr) < WIDE_W'(CELL_COUNT))
    else $error("cell write beyond the store");

    // a scroll leaves the cursor at the start of the bottom row
    assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DONE && res_scrolled_reg
            |-> cursor_wide == WIDE_W'(CELL_COUNT - COLUMNS))
    else $error("cursor not on bottom row after scroll");

endmodule

// ===== test/text_console_cell_writer_core_test.sv =====
// self-checking testbench for the text console cell writer core
module text_console_cell_writer_core_test;
    import tcw_pkg::*;

    localparam int COLS         = COLUMNS_DEF;
    localparam int LINES        = ROWS_DEF;
    localparam int CELLS        = COLS * LINES;
    localparam int PLAN_N       = 22;
    localparam int PHASE_WORDS  = 112;
    localparam int STALL_LIMIT  = 40000;

    typedef struct packed {
        tcw_in_t  word;
        logic     fixed;
        tcw_out_t want;
    } plan_row_t;

    logic              clk;
    logic              rst_n;
    logic              in_valid;
    logic              in_ready;
    tcw_in_t           in_data;
    logic              out_valid;
    logic              out_ready;
    tcw_out_t          out_data;
    logic              cfg_we;
    logic [BYTE_W-1:0] cfg_data;

    logic [CELL_W-1:0] shadow_cells [CELLS];
    logic [POS_W-1:0]  shadow_cursor;
    logic [BYTE_W-1:0] shadow_blank;

    tcw_out_t  awaited_q [$];
    tcw_out_t  want_word;
    plan_row_t plan [PLAN_N];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bad_count      = 0;
    int words_sent     = 0;
    int results_seen   = 0;
    int scroll_count   = 0;
    int clear_count    = 0;
    int quiet_cycles   = 0;

    text_console_cell_writer_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic void blank_screen();
        for (int i = 0; i < CELLS; i++)
        begin
            shadow_cells[i] = {shadow_blank, BLANK_CHAR};
        end
    endfunction

    function automatic tcw_out_t apply_console_word(tcw_in_t w);
        tcw_out_t    r;
        int unsigned spot;
        r    = '0;
        spot = shadow_cursor;
        case (w.kind)
            KIND_PUT:
            begin
                if (w.character == NEWLINE_CHAR)
                begin
                    spot = (spot / COLS + 1) * COLS;
                end
                else
                begin
                    shadow_cells[spot] = {w.color, w.character};
                    spot = spot + 1;
                end
                if (spot >= CELLS)
                begin
                    for (int i = 0; i < CELLS - COLS; i++)
                    begin
                        shadow_cells[i] = shadow_cells[i + COLS];
                    end
                    for (int i = CELLS - COLS; i < CELLS; i++)
                    begin
                        shadow_cells[i] = {shadow_blank, BLANK_CHAR};
                    end
                    spot       = CELLS - COLS;
                    r.scrolled = 1'b1;
                    scroll_count++;
                end
                shadow_cursor = POS_W'(spot);
            end
            KIND_CLEAR:
            begin
                blank_screen();
                shadow_cursor = '0;
                clear_count++;
            end
            KIND_READ:
            begin
                if (w.position < CELLS)
                begin
                    r.cell_value = shadow_cells[w.position];
                end
            end
            default:
            begin
                if (w.position < CELLS)
                begin
                    shadow_cursor = w.position;
                end
            end
        endcase
        r.cursor_position = shadow_cursor;
        return r;
    endfunction

    function automatic tcw_in_t random_word();
        tcw_in_t     w;
        int unsigned r;
        int unsigned pick;
        w.kind      = KIND_PUT;
        w.character = BYTE_W'($urandom_range(255));
        w.color     = BYTE_W'($urandom_range(255));
        w.position  = POS_W'($urandom_range(2047));
        r    = $urandom_range(99);
        pick = $urandom_range(99);
        if (r < 2)
        begin
            w.kind = KIND_CLEAR;
        end
        else if (r < 60)
        begin
            if (pick < 12)
            begin
                w.character = NEWLINE_CHAR;
            end
        end
        else if (r < 80)
        begin
            w.kind = KIND_READ;
            if (pick < 40)
            begin
                w.position = POS_W'((shadow_cursor + CELLS - 1 - $urandom_range(COLS)) % CELLS);
            end
            else if (pick < 80)
            begin
                w.position = POS_W'($urandom_range(CELLS - 1));
            end
            else if (pick < 90)
            begin
                w.position = POS_W'($urandom_range(CELLS - 1, CELLS - COLS));
            end
            else
            begin
                w.position = POS_W'($urandom_range(2047, CELLS));
            end
        end
        else
        begin
            w.kind = KIND_SETCUR;
            if (pick < 35)
            begin
                w.position = POS_W'($urandom_range(CELLS - 1, CELLS - 8));
            end
            else if (pick < 75)
            begin
                w.position = POS_W'($urandom_range(CELLS - 1));
            end
            else
            begin
                w.position = POS_W'($urandom_range(2047, CELLS));
            end
        end
        return w;
    endfunction

    function automatic plan_row_t row(logic [KIND_W-1:0] kind, logic [BYTE_W-1:0] character,
                                      logic [BYTE_W-1:0] color, int position, logic fixed,
                                      logic [CELL_W-1:0] value, int cur, logic scr);
        plan_row_t p;
        p.word.kind            = kind;
        p.word.character       = character;
        p.word.color           = color;
        p.word.position        = POS_W'(position);
        p.fixed                = fixed;
        p.want.cell_value      = value;
        p.want.cursor_position = POS_W'(cur);
        p.want.scrolled        = scr;
        return p;
    endfunction

    task automatic send_word(tcw_in_t w, logic fixed, tcw_out_t fixed_want);
        tcw_out_t predicted;
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = w;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = apply_console_word(w);
        awaited_q.push_back(fixed ? fixed_want : predicted);
        words_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid = 1'b0;
        while (awaited_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_blank(logic [BYTE_W-1:0] value);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_data = value;
        @(negedge clk);
        cfg_we   = 1'b0;
        shadow_blank = value;
    endtask

    task automatic report(string what, tcw_out_t want, tcw_out_t got);
        bad_count++;
        if (bad_count <= 10)
        begin
            $display("%s: want value %h cursor %0d scrolled %0d, got value %h cursor %0d scrolled %0d",
                     what, want.cell_value, want.cursor_position, want.scrolled,
                     got.cell_value, got.cursor_position, got.scrolled);
        end
    endtask

    // receiver stall pattern
    always @(negedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (awaited_q.size() == 0)
            begin
                report("unexpected word", '0, out_data);
            end
            else
            begin
                want_word = awaited_q.pop_front();
                if (out_data.cell_value !== want_word.cell_value ||
                    out_data.cursor_position !== want_word.cursor_position ||
                    out_data.scrolled !== want_word.scrolled)
                begin
                    report("wrong word", want_word, out_data);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("timeout after %0d quiet cycles, %0d words pending",
                     quiet_cycles, awaited_q.size());
            $display("text_console_cell_writer_core: mismatch");
            $finish;
        end
    end

    initial
    begin
        tcw_in_t           clear_word;
        logic [BYTE_W-1:0] blank_pick [4];
        int                idle_pick [4][2];

        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_data  = '0;

        shadow_blank  = BLANK_COLOR_RST;
        shadow_cursor = '0;
        blank_screen();

        plan[0]  = row(KIND_READ,   8'h00, 8'h00, 0,     1, {BLANK_COLOR_RST, BLANK_CHAR}, 0, 0);
        plan[1]  = row(KIND_READ,   8'h00, 8'h00, 1999,  1, {BLANK_COLOR_RST, BLANK_CHAR}, 0, 0);
        plan[2]  = row(KIND_READ,   8'hff, 8'hff, 2047,  1, 16'h0000, 0, 0);
        plan[3]  = row(KIND_PUT,    8'h41, 8'h1e, 0,     1, 16'h0000, 1, 0);
        plan[4]  = row(KIND_READ,   8'h00, 8'h00, 0,     1, 16'h1e41, 1, 0);
        plan[5]  = row(KIND_PUT,    8'hff, 8'hff, 2047,  1, 16'h0000, 2, 0);
        plan[6]  = row(KIND_PUT,    8'h00, 8'h00, 0,     1, 16'h0000, 3, 0);
        plan[7]  = row(KIND_PUT,    NEWLINE_CHAR, 8'h07, 0, 1, 16'h0000, 80, 0);
        plan[8]  = row(KIND_SETCUR, 8'h00, 8'h00, 2000,  1, 16'h0000, 80, 0);
        plan[9]  = row(KIND_SETCUR, 8'h00, 8'h00, 2047,  1, 16'h0000, 80, 0);
        plan[10] = row(KIND_SETCUR, 8'h00, 8'h00, 1000,  0, 16'h0000, 0, 0);
        plan[11] = row(KIND_PUT,    NEWLINE_CHAR, 8'h00, 0, 0, 16'h0000, 0, 0);
        plan[12] = row(KIND_SETCUR, 8'h00, 8'h00, 79,    0, 16'h0000, 0, 0);
        plan[13] = row(KIND_PUT,    8'h78, 8'h2c, 0,     0, 16'h0000, 0, 0);
        plan[14] = row(KIND_SETCUR, 8'h00, 8'h00, 1999,  1, 16'h0000, 1999, 0);
        plan[15] = row(KIND_PUT,    8'h5a, 8'h70, 0,     1, 16'h0000, 1920, 1);
        plan[16] = row(KIND_READ,   8'h00, 8'h00, 1919,  0, 16'h0000, 0, 0);
        plan[17] = row(KIND_READ,   8'h00, 8'h00, 1920,  1, {BLANK_COLOR_RST, BLANK_CHAR}, 1920, 0);
        plan[18] = row(KIND_PUT,    NEWLINE_CHAR, 8'h00, 0, 1, 16'h0000, 1920, 1);
        plan[19] = row(KIND_READ,   8'h00, 8'h00, 0,     0, 16'h0000, 0, 0);
        plan[20] = row(KIND_CLEAR,  8'h00, 8'h00, 0,     1, 16'h0000, 0, 0);
        plan[21] = row(KIND_READ,   8'h00, 8'h00, 1919,  1, {BLANK_COLOR_RST, BLANK_CHAR}, 0, 0);

        blank_pick[0] = 8'h00;
        blank_pick[1] = 8'hff;
        blank_pick[2] = BYTE_W'($urandom_range(255));
        blank_pick[3] = BLANK_COLOR_RST;
        idle_pick     = '{'{68, 0}, '{0, 68}, '{20, 20}, '{0, 0}};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int i = 0; i < PLAN_N; i++)
        begin
            send_word(plan[i].word, plan[i].fixed, plan[i].want);
        end
        wait_drained();

        clear_word = '0;
        clear_word.kind = KIND_CLEAR;
        for (int p = 0; p < 4; p++)
        begin
            write_blank(blank_pick[p]);
            send_idle_pct  = idle_pick[p][0];
            recv_stall_pct = idle_pick[p][1];
            send_word(clear_word, 1'b0, '0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                send_word(random_word(), 1'b0, '0);
            end
            wait_drained();
        end

        repeat (20) @(posedge clk);
        $display("%0d words sent, %0d results taken, %0d scrolls and %0d clears predicted",
                 words_sent, results_seen, scroll_count, clear_count);
        $display("blank colors 00, ff, random and reset value used under four idle patterns");
        if (bad_count == 0)
        begin
            $display("text_console_cell_writer_core: match");
        end
        else
        begin
            $display("%0d bad words", bad_count);
            $display("text_console_cell_writer_core: mismatch");
        end
        $finish;
    end

endmodule
